// ===== rtl/u8sd_pkg.sv =====
// Shared types, constants and the lead-byte classifier for the UTF-8 stream decoder.
// No dependencies.
`default_nettype none
package u8sd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned SEQ_MAX  = 4;
  localparam int unsigned HOLD_MAX = 3;

  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_2B     = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_2B     = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_3B     = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_3B     = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_4B     = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_4B     = 8'hF0;
  localparam logic [CP_W-1:0]   REPL_CHAR   = 21'h00FFFD;

  // Sequence lengths announced by a lead byte
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  // One unit of work for the back end: a group of bytes decoded left to right.
  typedef struct packed {
    logic [SEQ_MAX-1:0][BYTE_W-1:0] bytes;  // entry 0 first
    logic [2:0]                     cnt;    // 1..4 valid bytes
    logic                           eos;    // group closes the string
  } work_t;

  function automatic logic [2:0] seq_len(input logic [BYTE_W-1:0] c);
    logic [2:0] n;
    begin
      if (c < ASCII_LIMIT) begin
        n = LEN_1;
      end else if ((c & MASK_2B) == LEAD_2B) begin
        n = LEN_2;
      end else if ((c & MASK_3B) == LEAD_3B) begin
        n = LEN_3;
      end else if ((c & MASK_4B) == LEAD_4B) begin
        n = LEN_4;
      end else begin
        n = LEN_BAD;
      end
      return n;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/u8sd_front.sv =====
// Front end: takes bytes, holds the open sequence and hands complete or
// end-of-string groups to the work queue. Depends on u8sd_pkg.
`default_nettype none
module u8sd_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_end_of_string,
  input  wire logic                        q_full,
  output logic                             q_push,
  output u8sd_pkg::work_t                  q_wdata
);

  logic [u8sd_pkg::HOLD_MAX-1:0][7:0] pend_r, pend_nxt;
  logic [1:0]                         cnt_r, cnt_nxt;
  logic                               acc;
  logic [7:0]                         lead;
  logic [2:0]                         need;
  logic [2:0]                         total;
  logic                               complete;

  assign acc = in_push && !q_full;

  always_comb begin
    lead     = (cnt_r == 2'd0) ? in_data_byte : pend_r[0];
    need     = u8sd_pkg::seq_len(lead);
    total    = {1'b0, cnt_r} + 3'd1;
    complete = (total >= need);

    for (int i = 0; i < u8sd_pkg::SEQ_MAX; i++) begin
      if (i < int'(cnt_r)) begin
        q_wdata.bytes[i] = pend_r[i];
      end else if (i == int'(cnt_r)) begin
        q_wdata.bytes[i] = in_data_byte;
      end else begin
        q_wdata.bytes[i] = 8'h00;
      end
    end
    q_wdata.cnt = total;
    q_wdata.eos = in_end_of_string;
    q_push      = acc && (complete || in_end_of_string);

    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    if (acc) begin
      if (complete || in_end_of_string) begin
        cnt_nxt = 2'd0;
      end else begin
        for (int i = 0; i < u8sd_pkg::HOLD_MAX; i++) begin
          if (i == int'(cnt_r)) pend_nxt[i] = in_data_byte;
        end
        cnt_nxt = total[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  // A held sequence always starts with a multi-byte lead
  a_held_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0) |-> (u8sd_pkg::seq_len(pend_r[0]) >= u8sd_pkg::LEN_2))
    else $error("held bytes without a valid multi-byte lead");

  // End of string leaves nothing held
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_end_of_string) |=> (cnt_r == 2'd0))
    else $error("bytes still held after end of string");

endmodule
`default_nettype wire

// ===== rtl/u8sd_queue.sv =====
// Two-entry work queue between front and back end.
// Depends on u8sd_pkg.
`default_nettype none
module u8sd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire u8sd_pkg::work_t wdata,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output u8sd_pkg::work_t      rdata
);

  u8sd_pkg::work_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  // Front must never push into a full queue (a push would be dropped)
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("work queue overflow");

endmodule
`default_nettype wire

// ===== rtl/u8sd_back.sv =====
// Back end: walks each queued group into the result register, one code point per
// cycle while that register is empty or being popped. Depends on u8sd_pkg.
`default_nettype none
module u8sd_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_empty,
  input  wire u8sd_pkg::work_t         q_rdata,
  output logic                         q_pop,
  output logic                         out_empty,
  input  wire logic                    out_pop,
  output logic [u8sd_pkg::CP_W-1:0]    out_code_point,
  output logic                         out_last_result
);

  logic [1:0]                  pos_r, pos_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [u8sd_pkg::CP_W-1:0]   cp_r;
  logic                        last_r;

  logic [7:0]                  c, b1, b2, b3;
  logic [2:0]                  need, rem, adv;
  logic [3:0]                  next_pos;
  logic [u8sd_pkg::CP_W-1:0]   cp;
  logic                        done, step;

  always_comb begin
    c    = q_rdata.bytes[pos_r];
    b1   = q_rdata.bytes[pos_r + 2'd1];
    b2   = q_rdata.bytes[pos_r + 2'd2];
    b3   = q_rdata.bytes[pos_r + 2'd3];
    need = u8sd_pkg::seq_len(c);
    rem  = q_rdata.cnt - {1'b0, pos_r};
    adv  = 3'd1;
    cp   = u8sd_pkg::REPL_CHAR;

    if (need == u8sd_pkg::LEN_1) begin
      cp = {13'd0, c};
    end else if ((need != u8sd_pkg::LEN_BAD) && (rem >= need)) begin
      adv = need;
      unique case (need)
        u8sd_pkg::LEN_2: cp = {10'd0, c[4:0], b1[5:0]};
        u8sd_pkg::LEN_3: cp = {5'd0, c[3:0], b1[5:0], b2[5:0]};
        u8sd_pkg::LEN_4: cp = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
        default:         cp = u8sd_pkg::REPL_CHAR;
      endcase
    end

    next_pos = {2'b00, pos_r} + {1'b0, adv};
    done     = (next_pos >= {1'b0, q_rdata.cnt});
    step     = !q_empty && (!out_valid_r || out_pop);
    q_pop    = step && done;

    out_valid_nxt = step || (out_valid_r && !out_pop);
    pos_nxt       = pos_r;
    if (step) pos_nxt = done ? 2'd0 : next_pos[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      cp_r   <= cp;
      last_r <= q_rdata.eos && done;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_code_point  = cp_r;
  assign out_last_result = last_r;

  // A group that is partly walked stays at the queue head
  a_mid_group: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != 2'd0) |-> !q_empty)
    else $error("walk position set with no group at queue head");

endmodule
`default_nettype wire

// ===== rtl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: front end, work queue, back end.
// Depends on u8sd_pkg, u8sd_front, u8sd_queue, u8sd_back.
//
// Usage:
//   Input side is a queue write port: a byte transaction completes on a
//   rising edge with in_push high and in_full low. in_end_of_string marks
//   the final byte of a string.
//   Result side is a queue read port: while out_empty is low the oldest
//   code point sits on out_code_point / out_last_result and the
//   transaction completes on an edge with out_pop high.
// Path: a byte that completes a sequence is written to the queue on
//   its accepting edge; the back end then loads its code point into the
//   result register once that group is at the queue head and the result
//   register is empty or being popped. Throughput: one byte per cycle
//   while in_full is low. The back end walks each group one code point at
//   a time; a string that ends inside an open sequence yields up to three
//   code points from one group while the two-entry queue absorbs new bytes.
// Stalls: when out_pop stays low the result register holds, the queue
//   fills and in_full rises; no transaction is lost or repeated.
// Reset: synchronous, active low; clears held bytes, queue and result
//   register. The block accepts bytes in the first cycle after reset.
`default_nettype none
module utf8_stream_decoder (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [7:0]                in_data_byte,
  input  wire logic                      in_end_of_string,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic [u8sd_pkg::CP_W-1:0]      out_code_point,
  output logic                           out_last_result
);

  logic            q_push, q_full, q_pop, q_empty;
  u8sd_pkg::work_t q_wdata, q_rdata;

  // Backpressure comes straight from the work queue
  assign in_full = q_full;

  u8sd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  u8sd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  u8sd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_code_point  (out_code_point),
    .out_last_result (out_last_result)
  );

endmodule
`default_nettype wire

// ===== tb/sv/utf8_stream_decoder_checker.sv =====
// Checker for the UTF-8 stream decoder: predicts code points from accepted bytes
// and compares every popped result. Depends on u8sd_pkg for widths and U+FFFD.
module utf8_stream_decoder_checker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire logic                 in_full,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_end_of_string,
  input  wire logic                 out_empty,
  input  wire logic                 out_pop,
  input  wire logic [u8sd_pkg::CP_W-1:0] out_code_point,
  input  wire logic                 out_last_result,
  output int                        fail_count,
  output int                        results_checked,
  output int                        code_points_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [u8sd_pkg::CP_W-1:0] cp_t;

  typedef struct packed {
    cp_t  cp;
    logic last;
  } code_point_t;

  code_point_t      expected_cps[$];
  logic [2:0][7:0]  held_bytes;
  int               held_count;

  initial begin
    fail_count       = 0;
    results_checked  = 0;
    code_points_owed = 0;
    held_bytes       = '0;
    held_count       = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns checker: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // length of the sequence a lead announces, 0 for a byte that cannot lead
  function automatic int lead_len(input logic [7:0] c);
    casez (c)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  // decode one sequence starting at pos of grp[0..len)
  function automatic cp_t decode_seq(input logic [3:0][7:0] grp, input int pos,
                                     input int len, output int adv);
    int          need;
    logic [31:0] v;
    need = lead_len(grp[pos]);
    adv  = 1;
    if (need == 1) return cp_t'(grp[pos]);
    if (need == 0 || (len - pos) < need) return u8sd_pkg::REPL_CHAR;
    case (need)
      2:       v = 32'(grp[pos] & 8'h1F);
      3:       v = 32'(grp[pos] & 8'h0F);
      default: v = 32'(grp[pos] & 8'h07);
    endcase
    for (int i = 1; i < need; i++) v = (v << 6) | 32'(grp[pos + i] & 8'h3F);
    adv = need;
    return cp_t'(v);
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic eos);
    logic [3:0][7:0] grp;
    cp_t             cps[4];
    code_point_t     ent;
    int              n, total, need, pos, adv;
    n   = 0;
    grp = '0;
    if (held_count == 0) begin
      need = lead_len(b);
      if (need <= 1) begin
        grp[0] = b;
        cps[n] = decode_seq(grp, 0, 1, adv);
        n++;
      end else begin
        held_bytes[0] = b;
        held_count    = 1;
      end
    end else begin
      total = held_count;
      for (int i = 0; i < total; i++) grp[i] = held_bytes[i];
      grp[total] = b;
      total++;
      need = lead_len(grp[0]);
      if (total >= need) begin
        cps[n] = decode_seq(grp, 0, total, adv);
        n++;
        held_count = 0;
      end else begin
        for (int i = 0; i < total; i++) held_bytes[i] = grp[i];
        held_count = total;
      end
    end
    // string ends inside a sequence: flush what is held
    if (eos && held_count != 0) begin
      grp   = '0;
      total = held_count;
      for (int i = 0; i < total; i++) grp[i] = held_bytes[i];
      pos = 0;
      while (pos < total && n < 4) begin
        cps[n] = decode_seq(grp, pos, total, adv);
        n++;
        pos += adv;
      end
      held_count = 0;
      held_bytes = '0;
    end
    for (int i = 0; i < n; i++) begin
      ent.cp       = cps[i];
      ent.last     = eos && (i == n - 1);
      expected_cps = {expected_cps, ent};
    end
  endtask

  always @(posedge clk) begin
    code_point_t want;
    if (!rst_n) begin
      expected_cps.delete();
      held_bytes = '0;
      held_count = 0;
    end else begin
      // results first: nothing accepted on this edge can be popped on it
      if (out_pop && !out_empty) begin
        if (expected_cps.size() == 0) begin
          report_mismatch("code point with no transaction owed", int'(out_code_point), 0);
        end else begin
          want = expected_cps.pop_front();
          if (out_code_point !== want.cp)
            report_mismatch("code_point", int'(out_code_point), int'(want.cp));
          if (out_last_result !== want.last)
            report_mismatch("last_result", int'(out_last_result), int'(want.last));
          results_checked++;
        end
      end
      if (in_push && !in_full) predict_byte(in_data_byte, in_end_of_string);
    end
    code_points_owed <= expected_cps.size();
  end

endmodule

// ===== tb/sv/utf8_stream_decoder_test.sv =====
// Top of the UTF-8 stream decoder bench: clock, reset, byte strings and pop pacing.
// Depends on u8sd_pkg, utf8_stream_decoder and utf8_stream_decoder_checker.
module utf8_stream_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      in_push          = 1'b0;
  logic [7:0]                in_data_byte     = 8'h00;
  logic                      in_end_of_string = 1'b0;
  logic                      out_pop          = 1'b0;
  logic                      in_full;
  logic                      out_empty;
  logic [u8sd_pkg::CP_W-1:0] out_code_point;
  logic                      out_last_result;

  int fail_count;
  int results_checked;
  int code_points_owed;

  // run bookkeeping for the summary
  int  bytes_sent    = 0;
  int  strings_sent  = 0;
  int  strings_cut   = 0;
  // no idling on either side while set
  bit  steady        = 1'b0;
  int  pop_hold      = 0;

  utf8_stream_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_code_point   (out_code_point),
    .out_last_result  (out_last_result)
  );

  utf8_stream_decoder_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_code_point   (out_code_point),
    .out_last_result  (out_last_result),
    .fail_count       (fail_count),
    .results_checked  (results_checked),
    .code_points_owed (code_points_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Pop side: mostly pops, roughly a quarter of cycles stalled, sometimes for a
  // short burst so the internal queue fills and in_full rises.
  always @(posedge clk) begin
    if (pop_hold > 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (steady) begin
      out_pop <= 1'b1;
    end else if ($urandom_range(0, 99) < 8) begin
      out_pop  <= 1'b0;
      pop_hold <= $urandom_range(0, 6);
    end else begin
      out_pop <= 1'b1;
    end
  end

  // One byte transaction. in_push stays high into the next call unless a gap
  // is drawn, so it is never dropped and raised on the same edge.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_push          <= 1'b1;
    in_data_byte     <= b;
    in_end_of_string <= eos;
    do @(posedge clk); while (in_full);
    bytes_sent++;
    if (eos) strings_sent++;
    if (!steady && $urandom_range(0, 99) < 13) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // continuation byte, now and then an arbitrary byte since these go unchecked
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Random string of mostly well-formed characters, some noise bytes, and a
  // fifth of the time the final character cut short before end of string.
  task automatic send_string();
    logic [7:0] str[$];
    int         n_chars, last_start, len, cls;
    n_chars    = $urandom_range(1, 8);
    last_start = 0;
    for (int k = 0; k < n_chars; k++) begin
      last_start = str.size();
      cls        = $urandom_range(0, 99);
      if (cls < 40) begin
        str = {str, 8'($urandom_range(0, 127))};
      end else if (cls < 60) begin
        str = {str, 8'hC0 | 8'($urandom_range(0, 31))};
        str = {str, cont_byte()};
      end else if (cls < 75) begin
        str = {str, 8'hE0 | 8'($urandom_range(0, 15))};
        repeat (2) str = {str, cont_byte()};
      end else if (cls < 85) begin
        str = {str, 8'hF0 | 8'($urandom_range(0, 7))};
        repeat (3) str = {str, cont_byte()};
      end else begin
        str = {str, 8'($urandom_range(0, 255))};
      end
    end
    len = str.size() - last_start;
    if (len > 1 && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, len - 1)) void'(str.pop_back());
      strings_cut++;
    end
    foreach (str[i]) send_byte(str[i], i == str.size() - 1);
  endtask

  initial begin
    bit drained;
    drained = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ASCII extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // two, three and four byte sequences
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
    // stray bytes at both ends of both bad ranges
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    // no validation: ASCII swallowed as continuation, overlong form
    send_byte(8'hC0, 1'b0);
    send_byte(8'h41, 1'b1);
    // cut short: held lead, stray and short lead each give U+FFFD
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'hE0, 1'b1);
    // lone lead at end of string, then a stray that ends a string
    send_byte(8'hDF, 1'b1);
    send_byte(8'hFF, 1'b1);

    while (bytes_sent < 275) begin
      steady = (bytes_sent >= 90 && bytes_sent < 150);
      // after 180 bytes: stop sending until every owed code point has been popped
      if (!drained && bytes_sent >= 180) begin
        in_push <= 1'b0;
        do @(posedge clk); while (code_points_owed != 0);
        drained = 1'b1;
      end
      send_string();
    end
    steady = 1'b0;

    in_push <= 1'b0;
    do @(posedge clk); while (code_points_owed != 0);
    repeat (10) @(posedge clk);

    $display("Ran %0d strings in %0d bytes, %0d ending inside a sequence;",
             strings_sent, bytes_sent, strings_cut);
    $display("checked %0d code points with stalls on both sides.", results_checked);
    if (fail_count == 0 && code_points_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/u8sd_pkg.sv
rtl/u8sd_front.sv
rtl/u8sd_queue.sv
rtl/u8sd_back.sv
rtl/utf8_stream_decoder.sv
tb/sv/utf8_stream_decoder_checker.sv
tb/sv/utf8_stream_decoder_test.sv
